@@ rtl/assert_macros.svh @@
// Assertion macros shared by the heap RTL.
// Uses clk_i and the active-low reset rst_ni of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Same-cycle implication checked outside reset.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/mhpq_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the heap.
// No dependencies.
package mhpq_pkg;

  localparam int unsigned DefCapacity    = 1024;
  localparam int unsigned DefPayloadBits = 32;
  localparam int unsigned KeyBits        = 16;
  localparam int unsigned TagBits        = 30;
  localparam int unsigned OpBits         = 2;
  localparam int unsigned StatusBits     = 3;

  localparam logic [OpBits-1:0] OpPush    = 2'd0;
  localparam logic [OpBits-1:0] OpReplace = 2'd1;
  localparam logic [OpBits-1:0] OpPop     = 2'd2;

  localparam logic [StatusBits-1:0] StDone     = 3'd0;
  localparam logic [StatusBits-1:0] StReplaced = 3'd1;
  localparam logic [StatusBits-1:0] StKept     = 3'd2;
  localparam logic [StatusBits-1:0] StFull     = 3'd3;
  localparam logic [StatusBits-1:0] StEmpty    = 3'd4;

  typedef enum logic [2:0] {
    RaIdx, RaParent, RaLeft, RaRight, RaRoot, RaLast
  } rd_sel_e;

  typedef enum logic [1:0] {
    WdEnt, WdRd, WdBest
  } wr_data_e;

  typedef enum logic [2:0] {
    IxHold, IxZero, IxCnt, IxInc, IxParent, IxBest
  } idx_op_e;

  typedef struct packed {
    logic                  load;
    logic                  rd_en;
    rd_sel_e               rd_sel;
    logic                  wr_en;
    wr_data_e              wr_data;
    idx_op_e               idx_op;
    logic                  cnt_inc;
    logic                  cnt_dec;
    logic                  ent_from_rd;
    logic                  left_cap;
    logic                  out_cap;
    logic                  out_clr;
    logic                  status_set;
    logic [StatusBits-1:0] status;
    logic                  out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OpBits-1:0] opcode;
    logic              full;
    logic              empty;
    logic              at_root;
    logic              parent_gt;
    logic              tag_hit;
    logic              key_gt;
    logic              scan_last;
    logic              no_left;
    logic              child_lt;
  } dp_stat_t;

endpackage

@@ rtl/mhpq_dp.sv @@
// Heap datapath: entry memory, fill count, index and working registers.
// Depends on mhpq_pkg and assert_macros.svh; driven by mhpq_ctrl commands.
`include "assert_macros.svh"

module mhpq_dp #(
  parameter int unsigned Capacity    = mhpq_pkg::DefCapacity,
  parameter int unsigned PayloadBits = mhpq_pkg::DefPayloadBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [mhpq_pkg::OpBits-1:0]         opcode_i,
  input  logic [mhpq_pkg::KeyBits-1:0]        entry_key_i,
  input  logic [mhpq_pkg::TagBits-1:0]        entry_tag_i,
  input  logic [PayloadBits-1:0]              entry_payload_i,
  input  mhpq_pkg::dp_cmd_t                   cmd_i,
  output mhpq_pkg::dp_stat_t                  stat_o,
  output logic [mhpq_pkg::StatusBits-1:0]     status_o,
  output logic [mhpq_pkg::KeyBits-1:0]        out_key_o,
  output logic [mhpq_pkg::TagBits-1:0]        out_tag_o,
  output logic [PayloadBits-1:0]              out_payload_o,
  output logic [$clog2(Capacity+1)-1:0]       entry_count_o,
  output logic                                is_empty_o
);

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned ChW  = IdxW + 2;
  localparam int unsigned KeyW = mhpq_pkg::KeyBits;
  localparam int unsigned TagW = mhpq_pkg::TagBits;
  localparam int unsigned EntW = KeyW + TagW + PayloadBits;

  logic [EntW-1:0] mem [Capacity];

  logic [EntW-1:0] rd_q, ent_q, left_q, out_ent_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] rd_addr, parent_idx, last_idx, best_idx;
  logic [ChW-1:0]  cnt_x, left_x, right_x, next_x;
  logic [mhpq_pkg::OpBits-1:0] opcode_q;
  logic [mhpq_pkg::StatusBits-1:0] status_q;
  logic [EntW-1:0] best_ent;
  logic            has_right, right_lt;
  logic [KeyW-1:0] rd_key, ent_key, left_key, best_key;

  assign rd_key   = rd_q[EntW-1 -: KeyW];
  assign ent_key  = ent_q[EntW-1 -: KeyW];
  assign left_key = left_q[EntW-1 -: KeyW];

  assign cnt_x      = ChW'(cnt_q);
  assign left_x     = {1'b0, idx_q, 1'b1};
  assign right_x    = left_x + ChW'(1);
  assign next_x     = ChW'(idx_q) + ChW'(1);
  assign has_right  = right_x < cnt_x;
  assign parent_idx = (idx_q - IdxW'(1)) >> 1;
  assign last_idx   = IdxW'(cnt_q - CntW'(1));

  // Right child wins only when present and strictly smaller.
  assign right_lt = has_right && (rd_key < left_key);
  assign best_ent = right_lt ? rd_q : left_q;
  assign best_idx = right_lt ? right_x[IdxW-1:0] : left_x[IdxW-1:0];
  assign best_key = best_ent[EntW-1 -: KeyW];

  always_comb begin
    case (cmd_i.rd_sel)
      mhpq_pkg::RaIdx:    rd_addr = idx_q;
      mhpq_pkg::RaParent: rd_addr = parent_idx;
      mhpq_pkg::RaLeft:   rd_addr = left_x[IdxW-1:0];
      mhpq_pkg::RaRight:  rd_addr = right_x[IdxW-1:0];
      mhpq_pkg::RaLast:   rd_addr = last_idx;
      default:            rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      case (cmd_i.wr_data)
        mhpq_pkg::WdRd:   mem[idx_q] <= rd_q;
        mhpq_pkg::WdBest: mem[idx_q] <= best_ent;
        default:          mem[idx_q] <= ent_q;
      endcase
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_comb begin
    case (cmd_i.idx_op)
      mhpq_pkg::IxZero:   idx_d = '0;
      mhpq_pkg::IxCnt:    idx_d = IdxW'(cnt_q);
      mhpq_pkg::IxInc:    idx_d = next_x[IdxW-1:0];
      mhpq_pkg::IxParent: idx_d = parent_idx;
      mhpq_pkg::IxBest:   idx_d = best_idx;
      default:            idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      opcode_q <= opcode_i;
      ent_q    <= {entry_key_i, entry_tag_i, entry_payload_i};
    end else if (cmd_i.ent_from_rd) begin
      ent_q <= rd_q;
    end
    if (cmd_i.left_cap) begin
      left_q <= rd_q;
    end
    if (cmd_i.out_cap) begin
      out_ent_q <= rd_q;
    end else if (cmd_i.out_clr) begin
      out_ent_q <= '0;
    end
    if (cmd_i.status_set) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.out_load) begin
      status_o      <= status_q;
      out_key_o     <= out_ent_q[EntW-1 -: KeyW];
      out_tag_o     <= out_ent_q[PayloadBits +: TagW];
      out_payload_o <= out_ent_q[PayloadBits-1:0];
      entry_count_o <= cnt_q;
      is_empty_o    <= (cnt_q == '0);
    end
  end

  assign stat_o.opcode    = opcode_q;
  assign stat_o.full      = (cnt_q == CntW'(Capacity));
  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.at_root   = (idx_q == '0);
  assign stat_o.parent_gt = rd_key > ent_key;
  assign stat_o.tag_hit   = rd_q[PayloadBits +: TagW] == ent_q[PayloadBits +: TagW];
  assign stat_o.key_gt    = rd_key > ent_key;
  assign stat_o.scan_last = next_x == cnt_x;
  assign stat_o.no_left   = left_x >= cnt_x;
  assign stat_o.child_lt  = best_key < ent_key;

  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntW'(Capacity))
  `ASSERT_IMPLY(a_no_overfill, cmd_i.cnt_inc, cnt_q != CntW'(Capacity))
  `ASSERT_IMPLY(a_no_underflow, cmd_i.cnt_dec, cnt_q != '0)

endmodule

@@ rtl/mhpq_ctrl.sv @@
// Heap controller: sequences push, tag scan, sift up/down and the result transfer.
// Depends on mhpq_pkg and assert_macros.svh; drives mhpq_dp.
`include "assert_macros.svh"

module mhpq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  mhpq_pkg::dp_stat_t stat_i,
  output mhpq_pkg::dp_cmd_t  cmd_o
);

  localparam logic [4:0] SIdle    = 5'd0;
  localparam logic [4:0] SDisp    = 5'd1;
  localparam logic [4:0] SPush    = 5'd2;
  localparam logic [4:0] SUpRd    = 5'd3;
  localparam logic [4:0] SUpCmp   = 5'd4;
  localparam logic [4:0] SUpWr    = 5'd5;
  localparam logic [4:0] SRootRd  = 5'd6;
  localparam logic [4:0] SRootCap = 5'd7;
  localparam logic [4:0] SScanRd  = 5'd8;
  localparam logic [4:0] SScanCmp = 5'd9;
  localparam logic [4:0] SPopCap  = 5'd10;
  localparam logic [4:0] SPopLast = 5'd11;
  localparam logic [4:0] SDnRdL   = 5'd12;
  localparam logic [4:0] SDnRdR   = 5'd13;
  localparam logic [4:0] SDnCmp   = 5'd14;
  localparam logic [4:0] SDnWr    = 5'd15;
  localparam logic [4:0] SFinish  = 5'd16;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_held;

  assign out_held = out_valid_q && out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SDisp;
        end
      end
      SDisp: begin
        unique case (stat_i.opcode)
          mhpq_pkg::OpPush: state_d = SPush;
          mhpq_pkg::OpReplace: begin
            if (stat_i.empty) begin
              state_d = SPush;
            end else begin
              cmd_o.idx_op = mhpq_pkg::IxZero;
              state_d      = SScanRd;
            end
          end
          mhpq_pkg::OpPop: begin
            if (stat_i.empty) begin
              cmd_o.status_set = 1'b1;
              cmd_o.status     = mhpq_pkg::StEmpty;
              cmd_o.out_clr    = 1'b1;
              state_d          = SFinish;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = mhpq_pkg::RaRoot;
              state_d      = SPopCap;
            end
          end
          default: begin
            cmd_o.status_set = 1'b1;
            cmd_o.status     = mhpq_pkg::StKept;
            state_d          = SRootRd;
          end
        endcase
      end
      SPush: begin
        cmd_o.status_set = 1'b1;
        if (stat_i.full) begin
          cmd_o.status = mhpq_pkg::StFull;
          state_d      = SRootRd;
        end else begin
          cmd_o.status  = mhpq_pkg::StDone;
          cmd_o.idx_op  = mhpq_pkg::IxCnt;
          cmd_o.cnt_inc = 1'b1;
          state_d       = SUpRd;
        end
      end
      SUpRd: begin
        if (stat_i.at_root) begin
          state_d = SUpWr;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = mhpq_pkg::RaParent;
          state_d      = SUpCmp;
        end
      end
      SUpCmp: begin
        // Parent moves down into the hole while strictly greater.
        if (stat_i.parent_gt) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_data = mhpq_pkg::WdRd;
          cmd_o.idx_op  = mhpq_pkg::IxParent;
          state_d       = SUpRd;
        end else begin
          state_d = SUpWr;
        end
      end
      SUpWr: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_data = mhpq_pkg::WdEnt;
        state_d       = SRootRd;
      end
      SRootRd: begin
        if (stat_i.empty) begin
          cmd_o.out_clr = 1'b1;
          state_d       = SFinish;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = mhpq_pkg::RaRoot;
          state_d      = SRootCap;
        end
      end
      SRootCap: begin
        cmd_o.out_cap = 1'b1;
        state_d       = SFinish;
      end
      SScanRd: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = mhpq_pkg::RaIdx;
        state_d      = SScanCmp;
      end
      SScanCmp: begin
        if (stat_i.tag_hit) begin
          cmd_o.status_set = 1'b1;
          if (stat_i.key_gt) begin
            cmd_o.status = mhpq_pkg::StReplaced;
            state_d      = SUpRd;
          end else begin
            cmd_o.status = mhpq_pkg::StKept;
            state_d      = SRootRd;
          end
        end else if (stat_i.scan_last) begin
          state_d = SPush;
        end else begin
          cmd_o.idx_op = mhpq_pkg::IxInc;
          state_d      = SScanRd;
        end
      end
      SPopCap: begin
        cmd_o.out_cap    = 1'b1;
        cmd_o.status_set = 1'b1;
        cmd_o.status     = mhpq_pkg::StDone;
        cmd_o.rd_en      = 1'b1;
        cmd_o.rd_sel     = mhpq_pkg::RaLast;
        state_d          = SPopLast;
      end
      SPopLast: begin
        cmd_o.ent_from_rd = 1'b1;
        cmd_o.cnt_dec     = 1'b1;
        cmd_o.idx_op      = mhpq_pkg::IxZero;
        state_d           = SDnRdL;
      end
      SDnRdL: begin
        if (stat_i.no_left) begin
          state_d = SDnWr;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = mhpq_pkg::RaLeft;
          state_d      = SDnRdR;
        end
      end
      SDnRdR: begin
        cmd_o.left_cap = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = mhpq_pkg::RaRight;
        state_d        = SDnCmp;
      end
      SDnCmp: begin
        if (stat_i.child_lt) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_data = mhpq_pkg::WdBest;
          cmd_o.idx_op  = mhpq_pkg::IxBest;
          state_d       = SDnRdL;
        end else begin
          state_d = SDnWr;
        end
      end
      SDnWr: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_data = mhpq_pkg::WdEnt;
        state_d       = SFinish;
      end
      SFinish: begin
        if (!out_held) begin
          cmd_o.out_load = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;

  `ASSERT_IMPLY(a_no_result_overwrite, cmd_o.out_load, !out_held)
  `ASSERT_ALWAYS(a_cnt_one_way, !(cmd_o.cnt_inc && cmd_o.cnt_dec))
  `ASSERT_NEXT(a_accept_dispatch, state_q == SIdle && in_valid_i, state_q == SDisp)

endmodule

@@ rtl/min_heap_priority_queue.sv @@
// Binary min-heap priority queue with replace-by-tag: top level.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_dp.
//
// Input channel: in_valid_i/in_stall_o carry opcode, key, tag and payload;
// a transfer happens when valid is high and stall is low. Output channel:
// out_valid_o/out_stall_i carry status, the popped or root entry, the count
// and the empty flag. One result per input item.
// One item is worked at a time; the input is stalled until its result sits
// in the output register, which holds it while the receiver stalls, so the
// next item is taken while that result waits.
// A push or pop sift moves an entry across at most log2(CAPACITY) heap
// levels; replace first scans the entries for its tag, then sifts as a push.
// The next input transfer can come in the cycle after the result is loaded.
// Each step is bound by the single-port read of the entry memory.
// Reset clears the fill count and the handshake state; the entry memory is
// not cleared, only slots below the count are ever used.
module min_heap_priority_queue #(
  parameter int unsigned CAPACITY     = mhpq_pkg::DefCapacity,
  parameter int unsigned PAYLOAD_BITS = mhpq_pkg::DefPayloadBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mhpq_pkg::OpBits-1:0]     opcode_i,
  input  logic [mhpq_pkg::KeyBits-1:0]    entry_key_i,
  input  logic [mhpq_pkg::TagBits-1:0]    entry_tag_i,
  input  logic [PAYLOAD_BITS-1:0]         entry_payload_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mhpq_pkg::StatusBits-1:0] status_o,
  output logic [mhpq_pkg::KeyBits-1:0]    out_key_o,
  output logic [mhpq_pkg::TagBits-1:0]    out_tag_o,
  output logic [PAYLOAD_BITS-1:0]         out_payload_o,
  output logic [$clog2(CAPACITY+1)-1:0]   entry_count_o,
  output logic                            is_empty_o
);

  mhpq_pkg::dp_cmd_t  cmd;
  mhpq_pkg::dp_stat_t stat;

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mhpq_dp #(
    .Capacity    (CAPACITY),
    .PayloadBits (PAYLOAD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (opcode_i),
    .entry_key_i     (entry_key_i),
    .entry_tag_i     (entry_tag_i),
    .entry_payload_i (entry_payload_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .status_o        (status_o),
    .out_key_o       (out_key_o),
    .out_tag_o       (out_tag_o),
    .out_payload_o   (out_payload_o),
    .entry_count_o   (entry_count_o),
    .is_empty_o      (is_empty_o)
  );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for min_heap_priority_queue (default parameters).
// Depends on mhpq_pkg and the heap RTL; predicts every result in-line and
// checks it against the output channel.
module testbench;

  localparam int unsigned Cap = mhpq_pkg::DefCapacity;
  localparam int unsigned PayBits = mhpq_pkg::DefPayloadBits;
  localparam int unsigned KBits = mhpq_pkg::KeyBits;
  localparam int unsigned TBits = mhpq_pkg::TagBits;
  localparam int unsigned OBits = mhpq_pkg::OpBits;
  localparam int unsigned SBits = mhpq_pkg::StatusBits;
  localparam int unsigned CntBits = $clog2(Cap + 1);
  localparam int unsigned IdleLimit = 20000;
  // opcode with no operation behind it
  localparam logic [OBits-1:0] OpSpare = 2'd3;

  typedef struct packed {
    logic [SBits-1:0]   status;
    logic [KBits-1:0]   key;
    logic [TBits-1:0]   tag;
    logic [PayBits-1:0] pay;
    logic [CntBits-1:0] count;
    logic               empty;
  } heap_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OBits-1:0] opcode_i = mhpq_pkg::OpPush;
  logic [KBits-1:0] entry_key_i = '0;
  logic [TBits-1:0] entry_tag_i = '0;
  logic [PayBits-1:0] entry_payload_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [SBits-1:0] status_o;
  logic [KBits-1:0] out_key_o;
  logic [TBits-1:0] out_tag_o;
  logic [PayBits-1:0] out_payload_o;
  logic [CntBits-1:0] entry_count_o;
  logic is_empty_o;

  min_heap_priority_queue u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .entry_key_i,
    .entry_tag_i, .entry_payload_i, .out_valid_o, .out_stall_i, .status_o,
    .out_key_o, .out_tag_o, .out_payload_o, .entry_count_o, .is_empty_o
  );

  always #5 clk_i = ~clk_i;

  // shadow heap
  logic [KBits-1:0] hp_key[Cap];
  logic [TBits-1:0] hp_tag[Cap];
  logic [PayBits-1:0] hp_pay[Cap];
  int unsigned hp_count = 0;
  heap_result_t pending_q[$];

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit hold_req = 1'b0;

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [KBits-1:0] k;
    logic [TBits-1:0] t;
    logic [PayBits-1:0] p;
    k = hp_key[a]; t = hp_tag[a]; p = hp_pay[a];
    hp_key[a] = hp_key[b]; hp_tag[a] = hp_tag[b]; hp_pay[a] = hp_pay[b];
    hp_key[b] = k; hp_tag[b] = t; hp_pay[b] = p;
  endfunction

  function automatic void sift_up(int unsigned i);
    while (i >= 1 && hp_key[(i - 1) / 2] > hp_key[i]) begin
      swap_entries(i, (i - 1) / 2);
      i = (i - 1) / 2;
    end
  endfunction

  function automatic logic [SBits-1:0] heap_insert(
    logic [KBits-1:0] k, logic [TBits-1:0] t, logic [PayBits-1:0] p);
    if (hp_count >= Cap) return mhpq_pkg::StFull;
    hp_key[hp_count] = k; hp_tag[hp_count] = t; hp_pay[hp_count] = p;
    hp_count++;
    sift_up(hp_count - 1);
    return mhpq_pkg::StDone;
  endfunction

  function automatic heap_result_t heap_apply(logic [OBits-1:0] op,
    logic [KBits-1:0] k, logic [TBits-1:0] t, logic [PayBits-1:0] p);
    heap_result_t r;
    int unsigned i, c, l, best;
    bit popped, hit;
    r = '0;
    popped = 1'b0;
    if (op == mhpq_pkg::OpPush) begin
      r.status = heap_insert(k, t, p);
    end else if (op == mhpq_pkg::OpReplace) begin
      hit = 1'b0;
      r.status = mhpq_pkg::StKept;
      for (i = 0; i < hp_count; i++) begin
        if (hp_tag[i] == t) begin
          hit = 1'b1;
          break;
        end
      end
      if (!hit) begin
        r.status = heap_insert(k, t, p);
      end else if (hp_key[i] > k) begin
        hp_key[i] = k; hp_tag[i] = t; hp_pay[i] = p;
        sift_up(i);
        r.status = mhpq_pkg::StReplaced;
      end
    end else if (op == mhpq_pkg::OpPop) begin
      if (hp_count == 0) begin
        r.status = mhpq_pkg::StEmpty;
      end else begin
        r.key = hp_key[0]; r.tag = hp_tag[0]; r.pay = hp_pay[0];
        popped = 1'b1;
        hp_count--;
        hp_key[0] = hp_key[hp_count];
        hp_tag[0] = hp_tag[hp_count];
        hp_pay[0] = hp_pay[hp_count];
        c = 0;
        // left child wins ties; swap only while strictly smaller
        forever begin
          l = 2 * c + 1;
          best = c;
          if (l < hp_count && hp_key[l] < hp_key[best]) best = l;
          if (l + 1 < hp_count && hp_key[l + 1] < hp_key[best]) best = l + 1;
          if (best == c) break;
          swap_entries(c, best);
          c = best;
        end
        r.status = mhpq_pkg::StDone;
      end
    end else begin
      r.status = mhpq_pkg::StKept;
    end
    if (!popped && r.status != mhpq_pkg::StEmpty && hp_count > 0) begin
      r.key = hp_key[0]; r.tag = hp_tag[0]; r.pay = hp_pay[0];
    end
    r.count = hp_count[CntBits-1:0];
    r.empty = (hp_count == 0);
    return r;
  endfunction

  // Drives one item; valid stays high between items of a burst.
  task automatic send_item(logic [OBits-1:0] op, logic [KBits-1:0] k,
                           logic [TBits-1:0] t, logic [PayBits-1:0] p);
    int unsigned gap;
    heap_result_t res;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i = op; entry_key_i = k; entry_tag_i = t; entry_payload_i = p;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    res = heap_apply(op, k, t, p);
    pending_q = {pending_q, res};
  endtask

  // Receiver: random stalls at a density that is redrawn; hold-off overrides.
  initial begin
    int unsigned pct, n, held;
    pct = 0;
    n = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        for (held = 0; held < 400; held++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (n % 64 == 0) pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
      n++;
      out_stall_i = ($urandom_range(0, 99) < pct);
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    heap_result_t got, want;
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid_i && !in_stall_o) idle_cycles = 0;
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        got = '{status_o, out_key_o, out_tag_o, out_payload_o, entry_count_o, is_empty_o};
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, got);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
            errors++;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic test_corner_cases();
    send_item(mhpq_pkg::OpPop, 16'h1234, 30'h1, 32'h5);          // pop on empty
    send_item(OpSpare, 16'hFFFF, '1, '1);                         // unused opcode, empty
    send_item(mhpq_pkg::OpPush, 16'hFFFF, '1, '1);
    send_item(mhpq_pkg::OpPush, 16'h0000, '0, '0);
    send_item(mhpq_pkg::OpPush, 16'h0000, 30'h155, 32'hA5A5A5A5); // equal key, no swap
    send_item(mhpq_pkg::OpPush, 16'h8000, 30'h2AAAAAAA, 32'h5A5A5A5A);
    send_item(mhpq_pkg::OpReplace, 16'h9000, 30'h2AAAAAAA, 32'h1);  // larger key kept
    send_item(mhpq_pkg::OpReplace, 16'h8000, 30'h2AAAAAAA, 32'h2);  // equal key kept
    send_item(mhpq_pkg::OpReplace, 16'h0001, '1, 32'h3);            // decrease key
    send_item(mhpq_pkg::OpReplace, 16'h0000, 30'h2AAAAAAA, 32'h4);  // decrease to root tie
    send_item(mhpq_pkg::OpReplace, 16'h7777, 30'h3333, 32'hFFFF0000); // new tag pushes
    send_item(OpSpare, 16'h0, 30'h0, 32'h0);
    repeat (7) send_item(mhpq_pkg::OpPop, '0, '0, '0);              // drain past empty
  endtask

  task automatic test_full_heap();
    int unsigned i;
    for (i = 0; i < Cap; i++) begin
      if (i == Cap / 2) hold_req = 1'b1;  // back up the block mid-fill
      send_item(mhpq_pkg::OpPush, KBits'($urandom_range(0, 65535)), TBits'(i), $urandom());
    end
    send_item(mhpq_pkg::OpPush, 16'h0, 30'h3FFFFFFF, 32'h0);        // dropped
    send_item(mhpq_pkg::OpReplace, 16'h0, 30'h3FFFFFFE, 32'h0);     // new tag, dropped
    send_item(mhpq_pkg::OpReplace, 16'h0, TBits'(Cap - 1), 32'hDEADBEEF); // in place, full
    send_item(OpSpare, 16'h0, 30'h0, 32'h0);
    for (i = 0; i < 16; i++) begin
      send_item(mhpq_pkg::OpPop, KBits'($urandom()), TBits'($urandom()), $urandom());
    end
  endtask

  task automatic test_random_mix();
    int unsigned i, sel;
    logic [KBits-1:0] k;
    logic [TBits-1:0] t;
    for (i = 0; i < 24; i++) begin
      sel = $urandom_range(0, 99);
      k = KBits'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 15)
                                               : $urandom_range(0, 65535));
      t = TBits'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 63));
      if (sel < 40) send_item(mhpq_pkg::OpPush, k, t, $urandom());
      else if (sel < 65) send_item(mhpq_pkg::OpReplace, k, t, $urandom());
      else if (sel < 95) send_item(mhpq_pkg::OpPop, k, t, $urandom());
      else send_item(OpSpare, k, t, $urandom());
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_corner_cases();
    test_full_heap();
    test_random_mix();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    waited = 0;
    while (pending_q.size() != 0 && waited < IdleLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_dp.sv
rtl/mhpq_ctrl.sv
rtl/min_heap_priority_queue.sv
sim/testbench.sv
